/* rtl/fcfs_pkg.sv */
// Shared types and constants of the first come first served scheduling block.
// Used by fcfs_front, fcfs_queue, fcfs_back and fcfs_schedule_metrics.
`timescale 1ns / 1ps

package fcfs_pkg;

  localparam int MaxProcs = 16;
  localparam int CntW     = $clog2(MaxProcs + 1);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] arrival;
    logic [15:0] burst;
  } fcfs_rec_t;

  typedef struct packed {
    fcfs_rec_t rec;
    logic      store;
    logic      last;
  } fcfs_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } fcfs_state_e;

endpackage

/* rtl/fcfs_front.sv */
// Front end: accepts input items and marks each as stored or dropped.
// Depends on fcfs_pkg; feeds fcfs_queue.
`timescale 1ns / 1ps

module fcfs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        proc_tag_i,
  input  logic [15:0]        arrival_i,
  input  logic [15:0]        burst_i,
  input  logic               last_in_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output fcfs_pkg::fcfs_entry_t push_data_o
);

  logic [fcfs_pkg::CntW-1:0] fcnt_q, fcnt_d;
  logic                      store;
  logic                      accept;

  assign store        = fcnt_q < fcfs_pkg::CntW'(fcfs_pkg::MaxProcs);
  assign accept       = in_valid_i && push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  always_comb begin
    push_data_o.rec.tag     = proc_tag_i;
    push_data_o.rec.arrival = arrival_i;
    push_data_o.rec.burst   = burst_i;
    push_data_o.store       = store;
    push_data_o.last        = last_in_i;
  end

  always_comb begin
    fcnt_d = fcnt_q;
    if (accept) begin
      if (last_in_i) begin
        fcnt_d = '0;
      end else if (store) begin
        fcnt_d = fcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= '0;
    end else begin
      fcnt_q <= fcnt_d;
    end
  end

endmodule

/* rtl/fcfs_queue.sv */
// Short queue of classified items between the front end and the scheduler.
// Depends on fcfs_pkg.
`timescale 1ns / 1ps

module fcfs_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  fcfs_pkg::fcfs_entry_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output fcfs_pkg::fcfs_entry_t pop_data_o
);

  fcfs_pkg::fcfs_entry_t       mem [fcfs_pkg::QDepth];
  logic [fcfs_pkg::QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [fcfs_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                        push, pop;

  assign push_ready_o = cnt_q != fcfs_pkg::QCntW'(fcfs_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == fcfs_pkg::QPtrW'(fcfs_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == fcfs_pkg::QPtrW'(fcfs_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/fcfs_back.sv */
// Scheduler: insertion-sorts stored records into a row of cells, then serves
// them in order and drives the result register. Depends on fcfs_pkg.
`timescale 1ns / 1ps

module fcfs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  fcfs_pkg::fcfs_entry_t pop_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           out_tag_o,
  output logic [15:0]           out_arrival_o,
  output logic [15:0]           out_burst_o,
  output logic [23:0]           completion_o,
  output logic [23:0]           turnaround_o,
  output logic [23:0]           waiting_o,
  output logic [24:0]           total_turnaround_o,
  output logic [24:0]           total_waiting_o,
  output logic [4:0]            proc_count_o,
  output logic                  last_out_o
);

  fcfs_pkg::fcfs_state_e     state_q, state_d;
  fcfs_pkg::fcfs_rec_t       cells_q [fcfs_pkg::MaxProcs];
  fcfs_pkg::fcfs_rec_t       cells_d [fcfs_pkg::MaxProcs];
  logic [fcfs_pkg::MaxProcs-1:0] mv;
  logic [fcfs_pkg::CntW-1:0] cnt_q, cnt_d, k_q, k_d;
  logic [23:0]               clock_q, clock_d, start_q, wt_q;
  logic [24:0]               sum_tat_q, sum_tat_d, sum_wt_q, sum_wt_d;
  logic                      pop_en, calc_en, emit_en, emit_go, insert, run_last;
  logic [23:0]               head_at, start_c, ct_c, tat_c, wt_c;

  logic                      out_valid_q;
  logic [31:0]               tag_q;
  logic [15:0]               at_q, bt_q;
  logic [23:0]               ct_q, tat_q, wto_q;
  logic [24:0]               stat_q, swt_q;
  logic [4:0]                pcnt_q;
  logic                      lastout_q;

  always_comb begin
    pop_en  = 1'b0;
    calc_en = 1'b0;
    emit_en = 1'b0;
    case (state_q)
      fcfs_pkg::ST_LOAD: pop_en  = 1'b1;
      fcfs_pkg::ST_CALC: calc_en = 1'b1;
      fcfs_pkg::ST_EMIT: emit_en = 1'b1;
      default: ;
    endcase
  end

  assign pop_ready_o = pop_en;
  assign insert      = pop_en && pop_valid_i && pop_data_i.store;
  assign emit_go     = emit_en && (!out_valid_q || out_ready_i);
  assign run_last    = (fcfs_pkg::CntW'(k_q + 1'b1) == cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      fcfs_pkg::ST_LOAD: begin
        if (pop_valid_i && pop_data_i.last) begin
          state_d = fcfs_pkg::ST_CALC;
        end
      end
      fcfs_pkg::ST_CALC: state_d = fcfs_pkg::ST_EMIT;
      fcfs_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_d = run_last ? fcfs_pkg::ST_LOAD : fcfs_pkg::ST_CALC;
        end
      end
      default: state_d = fcfs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    for (int i = 0; i < fcfs_pkg::MaxProcs; i++) begin
      mv[i] = (fcfs_pkg::CntW'(i) >= cnt_q) ||
              (cells_q[i].arrival > pop_data_i.rec.arrival);
    end
    for (int i = 0; i < fcfs_pkg::MaxProcs; i++) begin
      cells_d[i] = cells_q[i];
    end
    if (insert) begin
      if (mv[0]) begin
        cells_d[0] = pop_data_i.rec;
      end
      for (int i = 1; i < fcfs_pkg::MaxProcs; i++) begin
        if (mv[i]) begin
          cells_d[i] = mv[i-1] ? cells_q[i-1] : pop_data_i.rec;
        end
      end
    end else if (emit_go) begin
      for (int i = 0; i < fcfs_pkg::MaxProcs - 1; i++) begin
        cells_d[i] = cells_q[i+1];
      end
    end
  end

  assign head_at = {8'd0, cells_q[0].arrival};
  assign start_c = (clock_q > head_at) ? clock_q : head_at;
  assign ct_c    = (cells_q[0].burst == '0) ? head_at : start_q + {8'd0, cells_q[0].burst};
  assign tat_c   = (cells_q[0].burst == '0) ? '0 : wt_q + {8'd0, cells_q[0].burst};
  assign wt_c    = (cells_q[0].burst == '0) ? '0 : wt_q;

  always_comb begin
    cnt_d     = cnt_q;
    k_d       = k_q;
    clock_d   = clock_q;
    sum_tat_d = sum_tat_q;
    sum_wt_d  = sum_wt_q;
    if (insert) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (emit_go) begin
      sum_tat_d = sum_tat_q + {1'b0, tat_c};
      sum_wt_d  = sum_wt_q + {1'b0, wt_c};
      if (cells_q[0].burst != '0) begin
        clock_d = ct_c;
      end
      k_d = k_q + 1'b1;
      if (run_last) begin
        cnt_d     = '0;
        k_d       = '0;
        clock_d   = '0;
        sum_tat_d = '0;
        sum_wt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fcfs_pkg::ST_LOAD;
      cnt_q       <= '0;
      k_q         <= '0;
      clock_q     <= '0;
      sum_tat_q   <= '0;
      sum_wt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      clock_q   <= clock_d;
      sum_tat_q <= sum_tat_d;
      sum_wt_q  <= sum_wt_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (calc_en) begin
      start_q <= start_c;
      wt_q    <= start_c - head_at;
    end
    if (emit_go) begin
      tag_q     <= cells_q[0].tag;
      at_q      <= cells_q[0].arrival;
      bt_q      <= cells_q[0].burst;
      ct_q      <= ct_c;
      tat_q     <= tat_c;
      wto_q     <= wt_c;
      stat_q    <= sum_tat_q + {1'b0, tat_c};
      swt_q     <= sum_wt_q + {1'b0, wt_c};
      pcnt_q    <= 5'(cnt_q);
      lastout_q <= run_last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_tag_o          = tag_q;
  assign out_arrival_o      = at_q;
  assign out_burst_o        = bt_q;
  assign completion_o       = ct_q;
  assign turnaround_o       = tat_q;
  assign waiting_o          = wto_q;
  assign total_turnaround_o = stat_q;
  assign total_waiting_o    = swt_q;
  assign proc_count_o       = pcnt_q;
  assign last_out_o         = lastout_q;

  // The table never holds more records than it has cells.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fcfs_pkg::CntW'(fcfs_pkg::MaxProcs))
    else $error("record count exceeds table size");

  // A run is only started over a table that holds at least one record.
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != fcfs_pkg::ST_LOAD) |-> (k_q < cnt_q))
    else $error("serving past the stored records");

  // The final result of a run returns the scheduler to an empty table.
  a_run_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && run_last) |=> (state_q == fcfs_pkg::ST_LOAD && cnt_q == '0 &&
                               clock_q == '0 && out_valid_q && last_out_o))
    else $error("run did not close cleanly");

endmodule

/* rtl/fcfs_schedule_metrics.sv */
// Top level of the first come first served scheduling block.
// Depends on fcfs_pkg, fcfs_front, fcfs_queue and fcfs_back.
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   proc_tag_i arrival_i burst_i last_in_i
// out      output     out_valid_o / out_ready_i out_tag_o .. last_out_o (10 fields)
// Records load at one item per cycle through a four-entry queue while the queue has room.
// The item marked last ends the set; each stored record is then served by a
// calc state that picks the start time and an emit state that finishes and registers
// the result, since each start depends on the completion of the one before.
// Reset clears all control state; the record cells need no reset.
// A stalled output holds its result while the queue keeps taking items until it is full.
`timescale 1ns / 1ps

module fcfs_schedule_metrics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] proc_tag_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] burst_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_tag_o,
  output logic [15:0] out_arrival_o,
  output logic [15:0] out_burst_o,
  output logic [23:0] completion_o,
  output logic [23:0] turnaround_o,
  output logic [23:0] waiting_o,
  output logic [24:0] total_turnaround_o,
  output logic [24:0] total_waiting_o,
  output logic [4:0]  proc_count_o,
  output logic        last_out_o
);

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  fcfs_pkg::fcfs_entry_t push_data, pop_data;

  fcfs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .proc_tag_i   (proc_tag_i),
    .arrival_i    (arrival_i),
    .burst_i      (burst_i),
    .last_in_i    (last_in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  fcfs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  fcfs_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .pop_ready_o        (pop_ready),
    .pop_data_i         (pop_data),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_tag_o          (out_tag_o),
    .out_arrival_o      (out_arrival_o),
    .out_burst_o        (out_burst_o),
    .completion_o       (completion_o),
    .turnaround_o       (turnaround_o),
    .waiting_o          (waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .proc_count_o       (proc_count_o),
    .last_out_o         (last_out_o)
  );

endmodule

/* tb/fcfs_schedule_metrics_tb.sv */
// Self-checking testbench for fcfs_schedule_metrics: a directed table, then random sets.
// A predictor models the stable sort and first come first served timing of each set.
// Depends on fcfs_pkg and the fcfs_schedule_metrics RTL.
`timescale 1ns / 1ps

module fcfs_schedule_metrics_tb;

  localparam int TotalItems  = 230;
  localparam int CalmAfter   = 190;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 40;
  localparam int DirRows     = 23;

  typedef struct packed {
    fcfs_pkg::fcfs_rec_t           rec;
    logic [23:0]                   completion;
    logic [23:0]                   turnaround;
    logic [23:0]                   waiting;
    logic [24:0]                   tot_turnaround;
    logic [24:0]                   tot_waiting;
    logic [fcfs_pkg::CntW-1:0]     count;
    logic                          last;
  } metrics_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] arr;
    logic [15:0] bur;
    logic        last;
    logic        fixed;
    logic [23:0] ct;
    logic [23:0] tat;
    logic [23:0] wt;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] proc_tag_i = '0;
  logic [15:0] arrival_i = '0;
  logic [15:0] burst_i = '0;
  logic        last_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [31:0] out_tag_o;
  logic [15:0] out_arrival_o;
  logic [15:0] out_burst_o;
  logic [23:0] completion_o;
  logic [23:0] turnaround_o;
  logic [23:0] waiting_o;
  logic [24:0] total_turnaround_o;
  logic [24:0] total_waiting_o;
  logic [4:0]  proc_count_o;
  logic        last_out_o;

  fcfs_pkg::fcfs_rec_t loaded_recs [$];
  metrics_t            pending_metrics [$];
  int        fails = 0;
  int        rec_count = 0;
  int        set_count = 0;
  int        dropped_count = 0;
  int        checked_count = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  dir_row_t dir_rows [DirRows] = '{
    '{32'h00000000, 16'd0,     16'd0,     1'b1, 1'b1, 24'd0,       24'd0,     24'd0},
    '{32'hFFFFFFFF, 16'hFFFF,  16'hFFFF,  1'b1, 1'b1, 24'h01FFFE,  24'h00FFFF, 24'd0},
    '{32'h50313030, 16'd100,   16'd0,     1'b1, 1'b1, 24'd100,     24'd0,     24'd0},
    '{32'hA5A5A5A5, 16'd0,     16'hFFFF,  1'b1, 1'b1, 24'h00FFFF,  24'h00FFFF, 24'd0},
    '{32'h00000201, 16'd40,    16'd5,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000202, 16'd10,    16'd50,    1'b1, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000301, 16'd5,     16'd4,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000302, 16'd3,     16'd2,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000303, 16'd3,     16'd0,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000304, 16'd20,    16'd6,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000305, 16'd0,     16'd1,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000306, 16'd3,     16'd7,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000307, 16'd100,   16'd10,    1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000308, 16'd100,   16'd0,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000309, 16'd50,    16'd3,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h0000030A, 16'd7,     16'd7,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h0000030B, 16'd0,     16'hFFFF,  1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h0000030C, 16'd200,   16'd1,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h0000030D, 16'd200,   16'd2,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h0000030E, 16'd150,   16'd0,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h0000030F, 16'd9,     16'd9,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000310, 16'd9,     16'd1,     1'b0, 1'b0, 24'd0,       24'd0,     24'd0},
    '{32'h00000311, 16'd1,     16'd1,     1'b1, 1'b0, 24'd0,       24'd0,     24'd0}
  };

  fcfs_schedule_metrics dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .proc_tag_i         (proc_tag_i),
    .arrival_i          (arrival_i),
    .burst_i            (burst_i),
    .last_in_i          (last_in_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_tag_o          (out_tag_o),
    .out_arrival_o      (out_arrival_o),
    .out_burst_o        (out_burst_o),
    .completion_o       (completion_o),
    .turnaround_o       (turnaround_o),
    .waiting_o          (waiting_o),
    .total_turnaround_o (total_turnaround_o),
    .total_waiting_o    (total_waiting_o),
    .proc_count_o       (proc_count_o),
    .last_out_o         (last_out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic schedule_record(input fcfs_pkg::fcfs_rec_t rec, input logic last);
    fcfs_pkg::fcfs_rec_t order [$];
    fcfs_pkg::fcfs_rec_t cur;
    metrics_t    m;
    logic [23:0] clock_q;
    logic [23:0] start;
    logic [23:0] arr24;
    logic [24:0] sum_tat;
    logic [24:0] sum_wt;
    int          j;
    if (loaded_recs.size() < fcfs_pkg::MaxProcs) begin
      loaded_recs.push_back(rec);
    end else begin
      dropped_count++;
    end
    if (last) begin
      order = loaded_recs;
      for (int i = 1; i < order.size(); i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && order[j - 1].arrival > cur.arrival) begin
          order[j] = order[j - 1];
          j--;
        end
        order[j] = cur;
      end
      clock_q = '0;
      sum_tat = '0;
      sum_wt = '0;
      for (int k = 0; k < order.size(); k++) begin
        arr24 = {8'd0, order[k].arrival};
        m.rec = order[k];
        if (order[k].burst == 16'd0) begin
          m.completion = arr24;
          m.turnaround = '0;
          m.waiting = '0;
        end else begin
          start = (clock_q > arr24) ? clock_q : arr24;
          m.completion = start + {8'd0, order[k].burst};
          clock_q = m.completion;
          m.turnaround = m.completion - arr24;
          m.waiting = start - arr24;
        end
        sum_tat = sum_tat + {1'b0, m.turnaround};
        sum_wt = sum_wt + {1'b0, m.waiting};
        m.tot_turnaround = sum_tat;
        m.tot_waiting = sum_wt;
        m.count = fcfs_pkg::CntW'(order.size());
        m.last = (k == order.size() - 1);
        pending_metrics.push_back(m);
      end
      loaded_recs.delete();
      set_count++;
    end
  endtask

  task automatic send_record(input fcfs_pkg::fcfs_rec_t rec, input logic last);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    proc_tag_i <= rec.tag;
    arrival_i <= rec.arrival;
    burst_i <= rec.burst;
    last_in_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    rec_count++;
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    metrics_t m;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_metrics.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual tag %h", $time, out_tag_o);
        fails++;
      end else begin
        m = pending_metrics.pop_front();
        check_field("out_tag", m.rec.tag, out_tag_o);
        check_field("out_arrival", 32'(m.rec.arrival), 32'(out_arrival_o));
        check_field("out_burst", 32'(m.rec.burst), 32'(out_burst_o));
        check_field("completion", 32'(m.completion), 32'(completion_o));
        check_field("turnaround", 32'(m.turnaround), 32'(turnaround_o));
        check_field("waiting", 32'(m.waiting), 32'(waiting_o));
        check_field("total_turnaround", 32'(m.tot_turnaround), 32'(total_turnaround_o));
        check_field("total_waiting", 32'(m.tot_waiting), 32'(total_waiting_o));
        check_field("proc_count", 32'(m.count), 32'(proc_count_o));
        check_field("last_out", 32'(m.last), 32'(last_out_o));
        checked_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t ns: no handshake for %0d cycles", $time, IdleLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    fcfs_pkg::fcfs_rec_t rec;
    metrics_t  m;
    int        set_size;
    int        amode;
    int        bmode;
    logic      last;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      rec.tag = dir_rows[i].tag;
      rec.arrival = dir_rows[i].arr;
      rec.burst = dir_rows[i].bur;
      send_record(rec, dir_rows[i].last);
      if (dir_rows[i].fixed) begin
        m.rec = rec;
        m.completion = dir_rows[i].ct;
        m.turnaround = dir_rows[i].tat;
        m.waiting = dir_rows[i].wt;
        m.tot_turnaround = {1'b0, dir_rows[i].tat};
        m.tot_waiting = {1'b0, dir_rows[i].wt};
        m.count = fcfs_pkg::CntW'(1);
        m.last = 1'b1;
        pending_metrics.push_back(m);
        set_count++;
      end else begin
        schedule_record(rec, dir_rows[i].last);
      end
    end

    while (rec_count < TotalItems) begin
      set_size = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      amode = $urandom_range(0, 2);
      bmode = $urandom_range(0, 2);
      for (int i = 0; i < set_size; i++) begin
        rec.tag = $urandom;
        case (amode)
          0: rec.arrival = 16'($urandom_range(0, 15));
          1: rec.arrival = 16'($urandom_range(0, 400));
          default: rec.arrival = 16'($urandom_range(0, 65535));
        endcase
        if ($urandom_range(0, 7) == 0) begin
          rec.burst = '0;
        end else begin
          case (bmode)
            0: rec.burst = 16'($urandom_range(1, 20));
            1: rec.burst = 16'($urandom_range(1, 1000));
            default: rec.burst = 16'($urandom_range(1, 65535));
          endcase
        end
        last = (i == set_size - 1);
        if (rec_count >= CalmAfter) calm = 1'b1;
        send_record(rec, last);
        schedule_record(rec, last);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_metrics.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d records in %0d sets, %0d dropped past a full table.",
             rec_count, set_count, dropped_count);
    $display("Checked %0d results against the scheduling predictor.", checked_count);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
